// ===== rtl/motion_input_sequence_matcher_unit_macros.svh =====
//----------------------------------------------------------------------------
// Motion input sequence matcher - assertion macros
// Shared concurrent assertion shorthands, clocked on clk and masked in reset.
//----------------------------------------------------------------------------
`ifndef MOTION_INPUT_SEQUENCE_MATCHER_UNIT_MACROS_SVH
`define MOTION_INPUT_SEQUENCE_MATCHER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/msm_pkg.sv =====
//----------------------------------------------------------------------------
// msm_pkg
// Types, constants and helpers for the motion input sequence matcher.
//----------------------------------------------------------------------------
package msm_pkg;

  // Default sizing
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int TAIL_WINDOW_DEF   = 4;
  localparam int MAX_STEPS_DEF     = 8;

  // Fixed field widths
  localparam int STEP_CNT_W = 4;
  localparam int PATTERN_W  = 64;
  localparam int TWIN_W     = 5;
  localparam int STEP_IDX_W = 3;
  localparam int CFG_IDX_W  = 2;

  // One history frame / pattern step: direction nibble, button nibble
  typedef logic [7:0] frame_t;

  // Direction codes (upper nibble)
  localparam logic [3:0] DIR_NEUTRAL    = 4'h0;
  localparam logic [3:0] DIR_UP         = 4'h1;
  localparam logic [3:0] DIR_DOWN       = 4'h2;
  localparam logic [3:0] DIR_LEFT       = 4'h3;
  localparam logic [3:0] DIR_RIGHT      = 4'h4;
  localparam logic [3:0] DIR_UP_LEFT    = 4'h5;
  localparam logic [3:0] DIR_UP_RIGHT   = 4'h6;
  localparam logic [3:0] DIR_DOWN_LEFT  = 4'h7;
  localparam logic [3:0] DIR_DOWN_RIGHT = 4'h8;
  localparam logic [3:0] DIR_ANY        = 4'hF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT    = 2'd0,
    CFG_PATTERN_STEPS = 2'd1,
    CFG_TOTAL_WINDOW  = 2'd2
  } cfg_idx_t;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_WAIT = 2'd2
  } msm_state_t;

  // A frame satisfies a step when the direction agrees (or the step takes
  // any direction) and every button of the step is present in the frame
  function automatic logic frame_fits(frame_t frame, frame_t step);
    logic dir_ok;
    logic btn_ok;
    dir_ok = (step[7:4] == DIR_ANY) || (step[7:4] == frame[7:4]);
    btn_ok = ((frame[3:0] & step[3:0]) == step[3:0]);
    return dir_ok && btn_ok;
  endfunction

endpackage

// ===== rtl/msm_in_if.sv =====
//----------------------------------------------------------------------------
// msm_in_if
// Input item channel: one pad frame or a history clear.
//----------------------------------------------------------------------------
interface msm_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] pad_held_bits;
  logic [2:0] pad_pressed_bits;

  modport source (output valid, output func, output pad_held_bits,
                  output pad_pressed_bits, input ready);
  modport sink   (input valid, input func, input pad_held_bits,
                  input pad_pressed_bits, output ready);
endinterface

// ===== rtl/msm_out_if.sv =====
//----------------------------------------------------------------------------
// msm_out_if
// Result item channel: match flag after each input item.
//----------------------------------------------------------------------------
interface msm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// ===== rtl/msm_cfg_if.sv =====
//----------------------------------------------------------------------------
// msm_cfg_if
// Configuration write channel: register index and write data.
//----------------------------------------------------------------------------
interface msm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/msm_encode.sv =====
//----------------------------------------------------------------------------
// msm_encode
// Packs a pad sample into a history frame: D-pad to direction code with
// diagonals first, pressed buttons into the low nibble.
//----------------------------------------------------------------------------
module msm_encode (
  input  logic [3:0]      pad_held_bits,
  input  logic [2:0]      pad_pressed_bits,
  output msm_pkg::frame_t frame
);
  import msm_pkg::*;

  logic       up_b, down_b, left_b, right_b;
  logic [3:0] dir;

  assign up_b    = pad_held_bits[0];
  assign down_b  = pad_held_bits[1];
  assign left_b  = pad_held_bits[2];
  assign right_b = pad_held_bits[3];

  // Priority: diagonals, then cardinals
  always_comb begin
    if (up_b && right_b)        dir = DIR_UP_RIGHT;
    else if (up_b && left_b)    dir = DIR_UP_LEFT;
    else if (down_b && right_b) dir = DIR_DOWN_RIGHT;
    else if (down_b && left_b)  dir = DIR_DOWN_LEFT;
    else if (up_b)              dir = DIR_UP;
    else if (down_b)            dir = DIR_DOWN;
    else if (left_b)            dir = DIR_LEFT;
    else if (right_b)           dir = DIR_RIGHT;
    else                        dir = DIR_NEUTRAL;
  end

  assign frame = {dir, 1'b0, pad_pressed_bits};

endmodule

// ===== rtl/motion_input_sequence_matcher_unit.sv =====
//----------------------------------------------------------------------------
// motion_input_sequence_matcher_unit
// Circular pad history with a step-pattern search after every item.
//----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per frame; func 0 pushes a pad sample, 1 clears history.
//   out_ch : exactly one item per input item, matched = pattern present.
//   cfg_ch : writes step_count (0), pattern_steps (1), total_window (2);
//            always ready, write only while the block is idle.
// Timing:
//   One item is handled at a time. After acceptance the history memory is
//   walked from the newest frame backwards, one entry per cycle through its
//   single registered read port, until the pattern resolves, the window
//   ends or the filled history runs out. The next item is taken the cycle
//   after the result enters the output register.
// Reset:
//   rst_n clears the configuration, fill count and newest pointer; the
//   history memory needs no sweep since only entries within the fill count
//   are ever used.
// Stall:
//   A result not yet taken holds in the output register; a later result
//   waits in the block and no new item is taken until it has moved out.
//----------------------------------------------------------------------------
module motion_input_sequence_matcher_unit #(
  parameter int HISTORY_DEPTH = msm_pkg::HISTORY_DEPTH_DEF,
  parameter int TAIL_WINDOW   = msm_pkg::TAIL_WINDOW_DEF,
  parameter int MAX_STEPS     = msm_pkg::MAX_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  msm_in_if.sink    in_ch,
  msm_out_if.source out_ch,
  msm_cfg_if.sink   cfg_ch
);
  import msm_pkg::*;
  `include "motion_input_sequence_matcher_unit_macros.svh"

  localparam int POS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int AGE_W  = $clog2(HISTORY_DEPTH + 2);
  localparam int CMP_W  = (AGE_W > TWIN_W) ? AGE_W : TWIN_W;

  localparam logic [POS_W-1:0]      LAST_POS = POS_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0]     FILL_MAX = FILL_W'(HISTORY_DEPTH);
  localparam logic [CMP_W-1:0]      FW_C     = CMP_W'(TAIL_WINDOW);
  localparam logic [CMP_W-1:0]      DEPTH_C  = CMP_W'(HISTORY_DEPTH);
  localparam logic [STEP_CNT_W-1:0] MAX_N    = STEP_CNT_W'(MAX_STEPS);

  // Configuration registers
  logic [STEP_CNT_W-1:0] step_count_r;
  logic [PATTERN_W-1:0]  pattern_steps_r;
  logic [TWIN_W-1:0]     total_window_r;

  // History pointers
  logic [POS_W-1:0]  newest_r, newest_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // Scan datapath
  msm_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [AGE_W-1:0]  rd_age_r, rd_age_nxt;
  logic [AGE_W-1:0]  cmp_age_r, cmp_age_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              final_r, final_nxt;
  logic [STEP_IDX_W-1:0] idx_r, idx_nxt;
  logic              res_r, res_nxt;
  frame_t            rd_data_r;

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;

  // History memory
  frame_t history [HISTORY_DEPTH];

  // Handshake and control strobes
  logic   in_ready;
  logic   in_acc;
  logic   scan_on;
  logic   out_load;
  logic   done;
  logic   done_val;
  frame_t new_frame;

  // Derived per-item values
  logic [STEP_CNT_W-1:0] n_eff;
  logic [CMP_W-1:0]      win_c;
  logic [CMP_W-1:0]      age_c;
  logic [CMP_W-1:0]      fill_c;
  logic                  lim_ok;
  frame_t                step_sel;
  logic                  fits;

  // Frame encoder
  msm_encode u_enc (
    .pad_held_bits    (in_ch.pad_held_bits),
    .pad_pressed_bits (in_ch.pad_pressed_bits),
    .frame            (new_frame)
  );

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r    <= '0;
      pattern_steps_r <= '0;
      total_window_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_STEP_COUNT:    step_count_r    <= cfg_ch.data[STEP_CNT_W-1:0];
        CFG_PATTERN_STEPS: pattern_steps_r <= cfg_ch.data;
        CFG_TOTAL_WINDOW:  total_window_r  <= cfg_ch.data[TWIN_W-1:0];
        default: ;
      endcase
    end
  end

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)   state_nxt = ST_SCAN;
      ST_SCAN: if (done)     state_nxt = ST_WAIT;
      ST_WAIT: if (out_load) state_nxt = ST_IDLE;
      default:               state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    scan_on  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scan_on  = 1'b1;
      ST_WAIT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  // Effective step count and search window
  assign n_eff  = (step_count_r > MAX_N) ? MAX_N : step_count_r;
  assign win_c  = (total_window_r == '0) ? DEPTH_C : CMP_W'(total_window_r);
  assign age_c  = CMP_W'(cmp_age_r);
  assign fill_c = CMP_W'(fill_r);

  // Compare stage: frame read last cycle against the current step
  assign step_sel = pattern_steps_r[{idx_r, 3'b000} +: 8];
  assign fits     = frame_fits(rd_data_r, step_sel);
  assign lim_ok   = (age_c < fill_c) && (final_r ? (age_c < FW_C) : (age_c < win_c));

  always_comb begin
    done     = 1'b0;
    done_val = 1'b0;
    idx_nxt   = idx_r;
    final_nxt = final_r;
    if (scan_on && cmp_vld_r) begin
      if (n_eff == '0 || !lim_ok) begin
        done = 1'b1;
      end else if (fits) begin
        if (idx_r == '0) begin
          done     = 1'b1;
          done_val = 1'b1;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          final_nxt = 1'b0;
        end
      end
    end
    if (in_acc) begin
      idx_nxt   = STEP_IDX_W'(n_eff - 1'b1);
      final_nxt = 1'b1;
    end
  end

  // History pointers and read address walk
  always_comb begin
    newest_nxt  = newest_r;
    fill_nxt    = fill_r;
    rd_pos_nxt  = rd_pos_r;
    rd_age_nxt  = rd_age_r;
    cmp_age_nxt = cmp_age_r;
    cmp_vld_nxt = cmp_vld_r;
    res_nxt     = res_r;
    if (in_acc) begin
      if (in_ch.func) begin
        newest_nxt = '0;
        fill_nxt   = '0;
      end else begin
        newest_nxt = (newest_r == LAST_POS) ? '0 : newest_r + 1'b1;
        fill_nxt   = (fill_r < FILL_MAX) ? fill_r + 1'b1 : fill_r;
      end
      rd_pos_nxt  = newest_nxt;
      rd_age_nxt  = '0;
      cmp_vld_nxt = 1'b0;
    end else if (scan_on) begin
      rd_pos_nxt  = (rd_pos_r == '0) ? LAST_POS : rd_pos_r - 1'b1;
      rd_age_nxt  = (done) ? rd_age_r : rd_age_r + 1'b1;
      cmp_age_nxt = rd_age_r;
      cmp_vld_nxt = !done;
      if (done) res_nxt = done_val;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = res_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = out_matched_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      newest_r    <= '0;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      fill_r      <= fill_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk) begin
    rd_pos_r      <= rd_pos_nxt;
    rd_age_r      <= rd_age_nxt;
    cmp_age_r     <= cmp_age_nxt;
    final_r       <= final_nxt;
    idx_r         <= idx_nxt;
    res_r         <= res_nxt;
    out_matched_r <= out_matched_nxt;
  end

  // History memory: write on push, registered read during the walk
  always_ff @(posedge clk) begin
    if (in_acc && !in_ch.func) history[newest_nxt] <= new_frame;
    if (scan_on) rd_data_r <= history[rd_pos_r];
  end

  // Checks
  `MSM_ASSERT_NEXT(a_clear_resets, in_acc && in_ch.func, fill_r == '0 && newest_r == '0, "clear left history pointers set")
  `MSM_ASSERT_NEXT(a_push_fills, in_acc && !in_ch.func && fill_r < FILL_MAX, fill_r == $past(fill_r) + 1'b1, "push did not grow fill count")
  `MSM_ASSERT_SAME(a_out_after_scan, $rose(out_valid_r), $past(state_r) == ST_WAIT, "result offered without a finished walk")

endmodule
